>>> rtl/csv_field_integer_parser_core_macros.svh
// Assertion macros shared by the checker of the CSV field integer parser.
// Each macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef CSV_FIELD_INTEGER_PARSER_CORE_MACROS_SVH
`define CSV_FIELD_INTEGER_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSVFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/csvfp_pkg.sv
// Shared types and constants of the CSV field integer parser.
// Used by the classifier, the word queue, the parse engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package csvfp_pkg;

  // Default size of the field window: FieldBufferChars - 1 characters count.
  localparam int unsigned FieldBufferCharsDefault = 64;

  // Depth of the queue between the classifier and the parse engine.
  localparam int unsigned QueueDepth = 2;

  // Register numbers, taken from address bit 2.
  localparam logic RegFieldIndex   = 1'b0;
  localparam logic RegDefaultValue = 1'b1;

  // One classified character.
  typedef struct packed {
    logic       is_eol;    // end of line
    logic       is_comma;  // field separator
    logic       is_blank;  // space, tab, newline, vertical tab, form feed, return
    logic       is_sign;   // '+' or '-'
    logic       is_minus;  // '-'
    logic       is_x;      // 'x' or 'X'
    logic       is_hexd;   // any hex digit
    logic [3:0] dval;      // digit value when is_hexd is set
  } csvfp_word_t;

  // Configuration registers as seen by the parse engine.
  typedef struct packed {
    logic [7:0]  field_index;
    logic [31:0] default_value;
  } csvfp_cfg_t;

endpackage

`default_nettype wire

>>> rtl/csvfp_front.sv
// Character classifier of the CSV field integer parser.
// Depends on csvfp_pkg for the classified word type.
`timescale 1ns / 1ps
`default_nettype none

module csvfp_front
  import csvfp_pkg::*;
(
  input  logic [7:0]  char_code,
  output csvfp_word_t word
);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  always_comb begin
    word          = '0;
    word.is_eol   = (char_code == CharNul);
    word.is_comma = (char_code == CharComma);
    word.is_blank = (char_code == CharSpace) ||
                    ((char_code >= CharTab) && (char_code <= CharCr));
    word.is_sign  = (char_code == CharPlus) || (char_code == CharMinus);
    word.is_minus = (char_code == CharMinus);
    word.is_x     = (char_code == CharLowX) || (char_code == CharUpX);
    if ((char_code >= CharZero) && (char_code <= CharNine)) begin
      word.is_hexd = 1'b1;
      word.dval    = 4'(char_code - CharZero);
    end else if ((char_code >= CharLowA) && (char_code <= CharLowF)) begin
      word.is_hexd = 1'b1;
      word.dval    = 4'(char_code - CharLowA + 8'd10);
    end else if ((char_code >= CharUpA) && (char_code <= CharUpF)) begin
      word.is_hexd = 1'b1;
      word.dval    = 4'(char_code - CharUpA + 8'd10);
    end
  end

endmodule

`default_nettype wire

>>> rtl/csvfp_queue.sv
// Short queue of classified words between the classifier and the parse engine.
// Depends on csvfp_pkg for the word type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module csvfp_queue
  import csvfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  csvfp_word_t push_word,
  output logic        pop_valid,
  input  logic        pop_ready,
  output csvfp_word_t pop_word
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(QueueDepth);

  csvfp_word_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != FullCount);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/csvfp_back.sv
// Parse engine of the CSV field integer parser: field tracking, number scan and result register.
// Depends on csvfp_pkg for the word and configuration types.
`timescale 1ns / 1ps
`default_nettype none

module csvfp_back
  import csvfp_pkg::*;
#(
  parameter int unsigned FieldBufferChars = FieldBufferCharsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  csvfp_cfg_t         cfg,
  input  logic               word_valid,
  output logic               word_ready,
  input  csvfp_word_t        word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               used_default
);

  localparam int unsigned CharsW = $clog2(FieldBufferChars);
  localparam logic [CharsW-1:0] CharsLimit = CharsW'(FieldBufferChars - 1);

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_HEXP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  phase_t             phase, phase_next;
  radix_t             radix, radix_next;
  logic [7:0]         field_count, field_count_next;
  logic [CharsW-1:0]  chars, chars_next;
  logic [31:0]        magnitude, magnitude_next;
  logic               negative, negative_next;
  logic               overflow, overflow_next;
  logic               digit_seen, digit_seen_next;
  logic               out_valid_next;
  logic signed [31:0] value_next;
  logic               used_default_next;

  logic        take;
  logic        in_field;
  logic        do_acc;
  logic        digit_fits;
  radix_t      acc_radix;
  logic [35:0] mag_ext;
  logic [35:0] acc_prod;
  logic [35:0] acc_sum;
  logic [35:0] acc_limit;
  logic        acc_over;
  logic        is_zero_char;
  logic        is_nonzero_dec;

  assign word_ready = !word.is_eol || !out_valid || out_ready;
  assign take       = word_valid && word_ready;
  assign in_field   = (field_count == cfg.field_index);

  assign is_zero_char   = word.is_hexd && (word.dval == 4'd0);
  assign is_nonzero_dec = word.is_hexd && (word.dval != 4'd0) && (word.dval < 4'd10);

  // Radix that a digit in the current phase is weighed with.
  always_comb begin
    unique case (phase)
      PH_SKIP, PH_SIGN: acc_radix = RX_DEC;
      PH_ZERO:          acc_radix = RX_OCT;
      PH_HEXP:          acc_radix = RX_HEX;
      default:          acc_radix = radix;
    endcase
  end

  always_comb begin
    case (radix)
      RX_OCT:  digit_fits = word.is_hexd && !word.dval[3];
      RX_HEX:  digit_fits = word.is_hexd;
      default: digit_fits = word.is_hexd && (word.dval < 4'd10);
    endcase
  end

  // Multiply by a constant radix with shifts, add the digit, check the signed range.
  always_comb begin
    mag_ext = 36'(magnitude);
    case (acc_radix)
      RX_OCT:  acc_prod = mag_ext << 3;
      RX_HEX:  acc_prod = mag_ext << 4;
      default: acc_prod = (mag_ext << 3) + (mag_ext << 1);
    endcase
    acc_sum   = acc_prod + 36'(word.dval);
    acc_limit = negative ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
    acc_over  = (acc_sum > acc_limit);
  end

  always_comb begin
    phase_next        = phase;
    radix_next        = radix;
    field_count_next  = field_count;
    chars_next        = chars;
    magnitude_next    = magnitude;
    negative_next     = negative;
    overflow_next     = overflow;
    digit_seen_next   = digit_seen;
    out_valid_next    = out_valid && !out_ready;
    value_next        = value;
    used_default_next = used_default;
    do_acc            = 1'b0;

    if (take) begin
      if (word.is_eol) begin
        out_valid_next    = 1'b1;
        used_default_next = (field_count < cfg.field_index) || !digit_seen || overflow;
        if (used_default_next) begin
          value_next = $signed(cfg.default_value);
        end else begin
          value_next = $signed(negative ? (32'd0 - magnitude) : magnitude);
        end
        field_count_next = '0;
        phase_next       = PH_SKIP;
        radix_next       = RX_DEC;
        chars_next       = '0;
        magnitude_next   = '0;
        negative_next    = 1'b0;
        overflow_next    = 1'b0;
        digit_seen_next  = 1'b0;
      end else if (word.is_comma) begin
        if (in_field) begin
          phase_next = PH_DONE;
        end else if (({1'b0, field_count} + 9'd1) == {1'b0, cfg.field_index}) begin
          // Entering the selected field: start a fresh parse.
          phase_next      = PH_SKIP;
          radix_next      = RX_DEC;
          chars_next      = '0;
          magnitude_next  = '0;
          negative_next   = 1'b0;
          overflow_next   = 1'b0;
          digit_seen_next = 1'b0;
        end
        if (field_count != 8'hFF) begin
          field_count_next = field_count + 8'd1;
        end
      end else if (in_field && (phase != PH_DONE) &&
                   !((phase == PH_SKIP) && word.is_blank)) begin
        if (chars >= CharsLimit) begin
          phase_next = PH_DONE;
        end else begin
          chars_next = chars + 1'b1;
          if ((phase == PH_SKIP) && word.is_sign) begin
            negative_next = word.is_minus;
            phase_next    = PH_SIGN;
          end else begin
            unique case (phase)
              PH_SKIP, PH_SIGN: begin
                if (is_zero_char) begin
                  digit_seen_next = 1'b1;
                  radix_next      = RX_OCT;
                  phase_next      = PH_ZERO;
                end else if (is_nonzero_dec) begin
                  radix_next = RX_DEC;
                  do_acc     = 1'b1;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              PH_ZERO: begin
                if (word.is_x) begin
                  phase_next = PH_HEXP;
                end else if (word.is_hexd && !word.dval[3]) begin
                  do_acc     = 1'b1;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              PH_HEXP: begin
                if (word.is_hexd) begin
                  radix_next = RX_HEX;
                  do_acc     = 1'b1;
                  phase_next = PH_DIGITS;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (digit_fits) begin
                  do_acc = 1'b1;
                end else begin
                  phase_next = PH_DONE;
                end
              end
              default: begin
                phase_next = PH_DONE;
              end
            endcase
          end
        end
      end
    end

    // Once the range is exceeded, later digits are consumed without effect.
    if (do_acc) begin
      digit_seen_next = 1'b1;
      if (!overflow) begin
        if (acc_over) begin
          overflow_next = 1'b1;
        end else begin
          magnitude_next = acc_sum[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SKIP;
      radix       <= RX_DEC;
      field_count <= '0;
      chars       <= '0;
      magnitude   <= '0;
      negative    <= 1'b0;
      overflow    <= 1'b0;
      digit_seen  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      radix       <= radix_next;
      field_count <= field_count_next;
      chars       <= chars_next;
      magnitude   <= magnitude_next;
      negative    <= negative_next;
      overflow    <= overflow_next;
      digit_seen  <= digit_seen_next;
      out_valid   <= out_valid_next;
    end
    value        <= value_next;
    used_default <= used_default_next;
  end

endmodule

`default_nettype wire

>>> rtl/csv_field_integer_parser_core.sv
// Top level of the CSV field integer parser: register port, classifier, queue, parse engine.
// Depends on csvfp_pkg, csvfp_front, csvfp_queue and csvfp_back.
//
// Usage: a text line enters on the input channel (char_code, in_valid, in_ready), one
// character per word, with code 0 closing the line. The field selected by field_index
// (byte address 0) is parsed like strtol with base 0; on the closing word one result
// word (value, used_default) leaves on the output channel (out_valid, out_ready).
// When no number could be read, the field is missing or the value leaves the signed
// 32-bit range, value carries default_value (byte address 4) and used_default is set.
// Throughput is one character per cycle while the queue is not full. With the queue empty
// and the result register free, an accepted end of line is first stored in the two-word
// queue, then the parse engine takes it, registers the result word and raises out_valid.
// The radix multiply-add and range compare on the 32-bit magnitude set the cycle.
// When the receiver stalls, characters keep being parsed up to the next end of line,
// which waits in the queue with the words behind it; in_ready drops once the queue holds
// two words. Synchronous reset empties the queue, drops out_valid, clears the parse state
// and sets both registers to zero. Registers are to be written only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_integer_parser_core
  import csvfp_pkg::*;
#(
  parameter int unsigned FIELD_BUFFER_CHARS = FieldBufferCharsDefault
) (
  input  logic               clk,
  input  logic               rst,
  // Character input.
  input  logic [7:0]         char_code,
  input  logic               in_valid,
  output logic               in_ready,
  // Result output.
  output logic signed [31:0] value,
  output logic               used_default,
  output logic               out_valid,
  input  logic               out_ready,
  // Register port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0]  field_index;
  logic [31:0] default_value;
  logic        reg_write;

  csvfp_cfg_t  cfg;
  csvfp_word_t front_word;
  csvfp_word_t head_word;
  logic        head_valid;
  logic        head_ready;

  // The register port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index   <= '0;
      default_value <= '0;
    end else if (reg_write) begin
      unique case (paddr[2])
        RegFieldIndex:   field_index   <= pwdata[7:0];
        RegDefaultValue: default_value <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegFieldIndex:   prdata = {24'd0, field_index};
      RegDefaultValue: prdata = default_value;
      default:         prdata = '0;
    endcase
  end

  assign cfg.field_index   = field_index;
  assign cfg.default_value = default_value;

  // Front: classify each character as it is accepted.
  csvfp_front u_front (
    .char_code (char_code),
    .word      (front_word)
  );

  csvfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_word  (front_word),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_word   (head_word)
  );

  // Back: track fields, scan the number and hold the result word.
  csvfp_back #(
    .FieldBufferChars (FIELD_BUFFER_CHARS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .word_valid   (head_valid),
    .word_ready   (head_ready),
    .word         (head_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .used_default (used_default)
  );

endmodule

`default_nettype wire

>>> rtl/csvfp_checker.sv
// Port-level checker of the CSV field integer parser, bound to the top level.
// Depends on csv_field_integer_parser_core_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "csv_field_integer_parser_core_macros.svh"

module csvfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] value,
  input logic        used_default,
  input logic        pready
);

  // The register port has no wait states.
  `CSVFP_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")

  // Leaving reset, no result word is offered.
  `CSVFP_ASSERT_NOW(a_idle_after_reset, $past(rst), !out_valid, "result offered right after reset")

  // A stalled result word holds its contents.
  `CSVFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(used_default), "stalled result changed")

  // The queue can only fill up through an accepted word.
  `CSVFP_ASSERT_NOW(a_ready_drop, !in_ready, $past(in_valid && in_ready) || $past(!in_ready), "in_ready dropped without an accepted word")

endmodule

bind csv_field_integer_parser_core csvfp_checker u_csvfp_checker (.*);

`default_nettype wire

>>> tb/csvfp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for csv_field_integer_parser_core: predicts each result word and compares it.
// Depends on csvfp_pkg for the register numbers and the default field window size.

module csvfp_result_checker
  import csvfp_pkg::*;
#(
  parameter int unsigned FIELD_BUFFER_CHARS = FieldBufferCharsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_code,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               used_default,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        mismatch_count,
  output int unsigned        pending_results
);

  localparam logic [7:0] EolChar   = 8'd0;
  localparam logic [7:0] CommaChar = 8'h2c;
  localparam logic [7:0] PlusChar  = 8'h2b;
  localparam logic [7:0] MinusChar = 8'h2d;
  localparam logic [4:0] NoDigit   = 5'd31;
  localparam int unsigned WindowChars = FIELD_BUFFER_CHARS - 1;

  typedef enum logic [2:0] {
    ScanSkip, ScanSign, ScanZero, ScanHexPrefix, ScanDigits, ScanDone
  } scan_phase_e;

  typedef enum logic [1:0] { RadixDec, RadixOct, RadixHex } radix_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               used_default;
  } result_word_t;

  // Shadow registers and parse state.
  logic [7:0]   sel_field;
  logic [31:0]  fallback;
  logic [7:0]   fields_passed;
  scan_phase_e  phase;
  int unsigned  window_used;
  logic [31:0]  mag;
  logic         negative;
  radix_e       radix;
  logic         too_big;
  logic         got_digit;

  result_word_t expected_words[$];
  result_word_t head;
  int unsigned  errors;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return NoDigit;
  endfunction

  function automatic logic [4:0] radix_base(input radix_e r);
    if (r == RadixOct) return 5'd8;
    if (r == RadixHex) return 5'd16;
    return 5'd10;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  task automatic clear_number();
    phase       = ScanSkip;
    window_used = 0;
    mag         = '0;
    negative    = 1'b0;
    radix       = RadixDec;
    too_big     = 1'b0;
    got_digit   = 1'b0;
  endtask

  // Multiply-add with the signed 32-bit range check; once out of range the
  // magnitude freezes but digits still count as seen.
  task automatic push_digit(input logic [4:0] d);
    logic [63:0] bound;
    logic [63:0] acc;
    bound = negative ? 64'd2147483648 : 64'd2147483647;
    got_digit = 1'b1;
    if (too_big) return;
    acc = {32'd0, mag} * radix_base(radix) + d;
    if (acc > bound) too_big = 1'b1;
    else mag = acc[31:0];
  endtask

  task automatic scan_number(input logic [7:0] c);
    logic [4:0] d;
    d = digit_value(c);
    if (phase == ScanSkip) begin
      if (c == PlusChar || c == MinusChar) begin
        negative = (c == MinusChar);
        phase = ScanSign;
        return;
      end
      phase = ScanSign;
    end
    case (phase)
      ScanSign: begin
        if (c == "0") begin
          got_digit = 1'b1;
          radix = RadixOct;
          phase = ScanZero;
        end else if (c >= "1" && c <= "9") begin
          radix = RadixDec;
          push_digit(d);
          phase = ScanDigits;
        end else begin
          phase = ScanDone;
        end
      end
      ScanZero: begin
        if (c == "x" || c == "X") phase = ScanHexPrefix;
        else if (d < 5'd8) begin
          push_digit(d);
          phase = ScanDigits;
        end else phase = ScanDone;
      end
      ScanHexPrefix: begin
        if (d < 5'd16) begin
          radix = RadixHex;
          push_digit(d);
          phase = ScanDigits;
        end else phase = ScanDone;
      end
      ScanDigits: begin
        if (d < radix_base(radix)) push_digit(d);
        else phase = ScanDone;
      end
      default: phase = ScanDone;
    endcase
  endtask

  task automatic track_char(input logic [7:0] c);
    result_word_t w;
    logic use_fallback;
    if (c == EolChar) begin
      use_fallback = fields_passed < sel_field || !got_digit || too_big;
      w.value = use_fallback ? fallback : (negative ? 32'd0 - mag : mag);
      w.used_default = use_fallback;
      expected_words.push_back(w);
      fields_passed = '0;
      clear_number();
      return;
    end
    if (c == CommaChar) begin
      if (fields_passed == sel_field) phase = ScanDone;
      else if ({1'b0, fields_passed} + 9'd1 == {1'b0, sel_field}) clear_number();
      if (fields_passed != 8'd255) fields_passed = fields_passed + 8'd1;
      return;
    end
    if (fields_passed != sel_field || phase == ScanDone) return;
    if (phase == ScanSkip && is_blank(c)) return;
    if (window_used >= WindowChars) begin
      phase = ScanDone;
      return;
    end
    window_used++;
    scan_number(c);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sel_field     = '0;
      fallback      = '0;
      fields_passed = '0;
      clear_number();
      expected_words.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no prediction waiting: value %0d used_default %0b",
                 value, used_default);
          errors++;
        end else begin
          head = expected_words.pop_front();
          if (value !== head.value) begin
            $error("value: expected %0d actual %0d", head.value, value);
            errors++;
          end
          if (used_default !== head.used_default) begin
            $error("used_default: expected %0b actual %0b", head.used_default, used_default);
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegFieldIndex) sel_field = pwdata[7:0];
        else fallback = pwdata;
      end
      if (in_valid && in_ready) track_char(char_code);
    end
    mismatch_count  <= errors;
    pending_results <= expected_words.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for csv_field_integer_parser_core: clock, reset, stimulus and verdict.
// Depends on csvfp_pkg, the block itself and csvfp_result_checker.

module testbench;
  import csvfp_pkg::*;

  // Byte addresses of the two registers.
  localparam logic [2:0] AddrFieldIndex   = 3'd0;
  localparam logic [2:0] AddrDefaultValue = 3'd4;

  localparam logic [7:0] EolChar   = 8'd0;
  localparam logic [7:0] CommaChar = 8'h2c;
  localparam logic [7:0] PlusChar  = 8'h2b;
  localparam logic [7:0] MinusChar = 8'h2d;

  // The block registers its answer once an end of line has passed the queue; the
  // settling time also covers any trailing character still in the queue.
  localparam int SettleCycles  = 8;
  localparam int RandomChars   = 1200;
  localparam int RandomPhases  = 6;
  localparam int CycleLimit    = 400000;

  logic               clk;
  logic               rst;
  logic [7:0]         char_code;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] value;
  logic               used_default;
  logic               out_valid;
  logic               out_ready;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int          cycle_count;

  // Percent of cycles in which each side holds back.
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;

  // The line under construction, without its closing end-of-line code.
  logic [7:0] line_chars[$];

  // Numbers at and just past the edges of the signed 32-bit range.
  string limit_texts [0:9] = '{
    "2147483647", "-2147483648", "2147483648", "-2147483649", "0x7fffffff",
    "-0x80000000", "0x80000000", "017777777777", "020000000000", "-0X80000001"
  };

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  csv_field_integer_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .char_code    (char_code),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .used_default (used_default),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  csvfp_result_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .char_code       (char_code),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value           (value),
    .used_default    (used_default),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // The receiver decides afresh at every falling edge whether to take a word,
  // so its stalls land on every phase of the block's work.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // Watchdog: a run that hangs ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("csv_field_integer_parser_core test failed");
    $finish;
  end

  // A register write: setup cycle, then access cycle until pready is seen.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One character word. Idle cycles are inserted before the word at the
  // sender's rate; valid then stays high until the word is taken. Each falling
  // edge carries at most one assignment to in_valid.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i]);
    send_char(EolChar);
    line_chars.delete();
  endtask

  // Stop sending until every predicted result word has left the block, then
  // let it settle. The first falling edge makes the checker's count current.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] field, input logic [31:0] fallback);
    drain();
    reg_write(AddrFieldIndex, {24'd0, field});
    reg_write(AddrDefaultValue, fallback);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endtask

  task automatic add_blank();
    int pick;
    pick = $urandom_range(0, 5);
    line_chars.push_back(pick == 5 ? 8'd32 : 8'(9 + pick));
  endtask

  // Any code but the end of line and the comma.
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CommaChar);
    return c;
  endfunction

  task automatic add_dec_digits(input int n);
    if (n <= 0) return;
    line_chars.push_back(8'("1" + $urandom_range(0, 8)));
    repeat (n - 1) line_chars.push_back(8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic add_oct_digits(input int n);
    repeat (n) line_chars.push_back(8'("0" + $urandom_range(0, 7)));
  endtask

  task automatic add_hex_digits(input int n);
    int d;
    repeat (n) begin
      d = $urandom_range(0, 15);
      if (d < 10) line_chars.push_back(8'("0" + d));
      else line_chars.push_back(8'(($urandom_range(0, 1) ? "A" : "a") + d - 10));
    end
  endtask

  // The selected field: leading blanks, an optional sign, then a number in
  // one of the shapes strtol accepts, or a broken one, at times with trailing text.
  task automatic add_number();
    int kind;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 3)) add_blank();
    if (kind != 6 && $urandom_range(0, 2) == 0)
      line_chars.push_back($urandom_range(0, 1) ? PlusChar : MinusChar);
    case (kind)
      0: add_dec_digits($urandom_range(1, 9));
      1: add_dec_digits($urandom_range(10, 12));
      2: begin
        add_str($urandom_range(0, 1) ? "0x" : "0X");
        add_hex_digits($urandom_range(1, 9));
      end
      3: begin
        add_str("0");
        add_oct_digits($urandom_range(0, 12));
      end
      4: begin
        add_str("0x");
        if ($urandom_range(0, 1)) line_chars.push_back(filler_char());
      end
      5: ;
      6: add_str(limit_texts[$urandom_range(0, 9)]);
      7: begin
        add_str("0");
        add_oct_digits($urandom_range(0, 3));
        add_str($urandom_range(0, 1) ? "8" : "9");
        add_oct_digits(2);
      end
      8: begin
        add_dec_digits($urandom_range(1, 4));
        add_str("q7");
      end
      default: repeat ($urandom_range(1, 5)) line_chars.push_back(filler_char());
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) line_chars.push_back(filler_char());
  endtask

  // A well-formed line: for field 6 or lower mostly long enough to reach the selected
  // field, else mostly short of it, so the missing-field case comes up too.
  task automatic build_field_line(input int field);
    int n_fields;
    if (field <= 6) begin
      if ($urandom_range(0, 3) != 0) n_fields = field + 1 + $urandom_range(0, 1);
      else n_fields = $urandom_range(1, field + 1);
    end else begin
      if ($urandom_range(0, 6) == 0) n_fields = field + 1 + $urandom_range(0, 3);
      else n_fields = $urandom_range(1, 4);
    end
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) line_chars.push_back(CommaChar);
      if (f == field) add_number();
      else repeat ($urandom_range(0, 5)) line_chars.push_back(filler_char());
    end
  endtask

  // Noise: any codes, commas included.
  task automatic build_noise_line();
    repeat ($urandom_range(0, 24)) line_chars.push_back(8'($urandom_range(1, 255)));
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        sender_idle_pct   = 20;
        receiver_idle_pct = 57;
      end
      1: begin
        sender_idle_pct   = 57;
        receiver_idle_pct = 20;
      end
      default: begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
    endcase
  endtask

  initial begin
    int unsigned cur_field;
    int          sent;
    bit          paused;

    rst       = 1'b1;
    char_code = '0;
    in_valid  = 1'b0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    set_idling(0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines with the reset registers: field 0, default 0.
    add_str("0"); send_line();
    repeat (2) add_blank();
    for (int b = 9; b <= 13; b++) line_chars.push_back(8'(b));
    line_chars.push_back(8'd32);
    add_str("-2147483648"); send_line();
    add_str("2147483647"); send_line();
    // Just past either end of the range the default comes back, unlike -0x80000000.
    add_str("2147483648"); send_line();
    add_str("-2147483649"); send_line();
    add_str("-0x80000000"); send_line();
    // A hex prefix with no hex digit reads as zero.
    add_str("0xg"); send_line();
    // Octal reading stops at an eight.
    add_str("0778"); send_line();
    // Sign alone, an empty line and a blank field give the default.
    add_str("+"); send_line();
    send_line();

    configure(8'd0, 32'h5a5a_5a5a);
    add_str(" "); send_line();
    add_str("12abc,5"); send_line();
    add_str("0XaBcDeF"); send_line();
    // Codes above 127 are neither digits nor blanks.
    line_chars.push_back(8'h80); add_str("1"); send_line();
    add_str("7"); line_chars.push_back(8'hff); add_str("9"); send_line();
    // An over-long field: only the first 63 characters after the blanks count.
    repeat (3) add_blank();
    repeat (60) add_str("0");
    add_str("1234"); send_line();

    configure(8'd2, 32'hffff_ffff);
    add_str(",,7"); send_line();
    add_str("1,2"); send_line();
    add_str("1,2,  -33 ,9"); send_line();

    configure(8'd1, 32'h8000_0000);
    add_str("99,  +0x10"); send_line();

    // Field 255: the comma count saturates, so commas past it close the field.
    configure(8'd255, 32'h7fff_ffff);
    repeat (255) line_chars.push_back(CommaChar);
    add_str("-42"); send_line();
    repeat (255) line_chars.push_back(CommaChar);
    add_str("12,,,,5"); send_line();
    add_str("1,2,3"); send_line();

    // Random part: six register settings, two per idling pattern. Every
    // setting change waits until the block has gone quiet.
    for (int p = 0; p < RandomPhases; p++) begin
      set_idling(p / 2);
      case (p)
        0: cur_field = 0;
        1: cur_field = 1;
        2: cur_field = 3;
        3: cur_field = 255;
        default: cur_field = $urandom_range(0, 7);
      endcase
      case (p)
        0: configure(8'(cur_field), 32'd0);
        1: configure(8'(cur_field), 32'h8000_0000);
        2: configure(8'(cur_field), 32'h7fff_ffff);
        3: configure(8'(cur_field), 32'hffff_ffff);
        default: configure(8'(cur_field), $urandom());
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < RandomChars / RandomPhases) begin
        if ($urandom_range(0, 4) == 0) build_noise_line();
        else build_field_line(cur_field);
        sent += line_chars.size() + 1;
        send_line();
        // Once in the last setting, hold the sender until the block is empty.
        if (p == RandomPhases - 1 && !paused && sent > RandomChars / (2 * RandomPhases)) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("csv_field_integer_parser_core test passed");
    end else begin
      $display("csv_field_integer_parser_core test failed");
    end
    $finish;
  end

endmodule
